// ===== rtl/debounced_toggle_telemetry_formatter_macros.svh =====
// Assertion macros shared by the telemetry formatter modules.
`ifndef DEBOUNCED_TOGGLE_TELEMETRY_FORMATTER_MACROS_SVH
`define DEBOUNCED_TOGGLE_TELEMETRY_FORMATTER_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during rst.
`define DTF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off during rst.
`define DTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dtf_pkg.sv =====
// Package with widths, text constants and control types of the telemetry formatter.
package dtf_pkg;

  localparam int TIME_W     = 32;
  localparam int TEMP_W     = 32;
  localparam int CHAR_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int BCD_DIGITS = 10;
  localparam int IDX_W      = 5;
  localparam int DIG_W      = 4;
  localparam int CNT_W      = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVALID  = 2'd1;

  localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 32'd50;
  localparam logic [TEMP_W-1:0] INVALID_RESET  = 32'h8000_0000;

  localparam int ON_LEN   = 21;
  localparam int OFF_LEN  = 22;
  localparam int TEMP_LEN = 5;

  localparam logic [8*ON_LEN-1:0]   ON_TEXT   = "equipment/0/state,on\n";
  localparam logic [8*OFF_LEN-1:0]  OFF_TEXT  = "equipment/0/state,off\n";
  localparam logic [8*TEMP_LEN-1:0] TEMP_TEXT = "temp,";

  localparam logic [IDX_W-1:0] ON_LAST   = IDX_W'(ON_LEN - 1);
  localparam logic [IDX_W-1:0] OFF_LAST  = IDX_W'(OFF_LEN - 1);
  localparam logic [IDX_W-1:0] TEMP_LAST = IDX_W'(TEMP_LEN - 1);

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;

  typedef enum logic [2:0] {
    SEL_EQ,
    SEL_TEMP,
    SEL_SIGN,
    SEL_DIGIT,
    SEL_DOT,
    SEL_FRAC,
    SEL_NL
  } sel_t;

  typedef struct packed {
    logic idle;
    logic emit;
    logic last;
    sel_t sel;
  } dtf_cmd_t;

  typedef struct packed {
    logic press_acc;
    logic has_temp;
    logic neg;
    logic conv_done;
    logic out_free;
    logic idx_end;
  } dtf_sts_t;

  function automatic logic [CHAR_W-1:0] eq_char(input logic on, input logic [IDX_W-1:0] i);
    logic [CHAR_W-1:0] ch;
    ch = CH_NL;
    if (on) begin
      if (int'(i) < ON_LEN) ch = ON_TEXT[8*(ON_LEN - 1 - int'(i)) +: 8];
    end else begin
      if (int'(i) < OFF_LEN) ch = OFF_TEXT[8*(OFF_LEN - 1 - int'(i)) +: 8];
    end
    return ch;
  endfunction

  function automatic logic [CHAR_W-1:0] temp_char(input logic [IDX_W-1:0] i);
    logic [CHAR_W-1:0] ch;
    ch = CH_NL;
    if (int'(i) < TEMP_LEN) ch = TEMP_TEXT[8*(TEMP_LEN - 1 - int'(i)) +: 8];
    return ch;
  endfunction

endpackage

// ===== rtl/dtf_if.sv =====
// Handshake interfaces for the sample, telemetry and configuration channels.
interface dtf_in_if;
  import dtf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     button_level;
  logic [TIME_W-1:0]        time_ms;
  logic signed [TEMP_W-1:0] temperature_tenths;
  modport source(output valid, button_level, time_ms, temperature_tenths, input ready);
  modport sink(input valid, button_level, time_ms, temperature_tenths, output ready);
endinterface

interface dtf_out_if;
  import dtf_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_byte;
  logic              equipment_state;
  modport source(output valid, char_code, last_byte, equipment_state, input ready);
  modport sink(input valid, char_code, last_byte, equipment_state, output ready);
endinterface

interface dtf_cfg_if;
  import dtf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TEMP_W-1:0]    data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/dtf_datapath.sv =====
// Datapath: debounce state, decimal conversion, byte selection and output register.
`include "debounced_toggle_telemetry_formatter_macros.svh"

module dtf_datapath (
  input  logic              clk,
  input  logic              rst,
  input  dtf_pkg::dtf_cmd_t cmd,
  output dtf_pkg::dtf_sts_t sts,
  dtf_cfg_if.sink           cfg,
  dtf_in_if.sink            sample,
  dtf_out_if.source         telemetry
);
  import dtf_pkg::*;

  logic [TIME_W-1:0]                 debounce_interval;
  logic signed [TEMP_W-1:0]          invalid_code;
  logic                              power_on;
  logic                              button_previous;
  logic [TIME_W-1:0]                 last_edge_time;
  logic                              edge_seen;
  logic                              has_temp;
  logic                              neg;
  logic [TEMP_W-1:0]                 mag;
  logic [BCD_DIGITS-1:0][3:0]        bcd;
  logic [CNT_W-1:0]                  conv_cnt;
  logic [IDX_W-1:0]                  idx;
  logic                              out_valid;
  logic [CHAR_W-1:0]                 out_char;
  logic                              out_last;
  logic                              out_eq;

  logic                              accept;
  logic                              press;
  logic                              press_acc;
  logic [TIME_W-1:0]                 elapsed;
  logic [TEMP_W-1:0]                 raw;
  logic [TEMP_W-1:0]                 mag_in;
  logic                              conv_done;
  logic [BCD_DIGITS-1:0][3:0]        bcd_adj;
  logic [4*BCD_DIGITS-1:0]           bcd_adj_flat;
  logic [DIG_W-1:0]                  top_pos;
  logic [DIG_W-1:0]                  dig_sel;
  logic                              idx_end;
  logic [CHAR_W-1:0]                 char_next;

  localparam logic [CNT_W-1:0] CONV_STEPS = CNT_W'(TEMP_W);

  assign sample.ready = cmd.idle;
  assign cfg.ready    = 1'b1;
  assign accept       = sample.valid && sample.ready;
  assign elapsed      = sample.time_ms - last_edge_time;
  assign press        = sample.button_level && !button_previous &&
                        (!edge_seen || (elapsed >= debounce_interval));
  assign press_acc    = accept && press;
  assign raw          = TEMP_W'(unsigned'(sample.temperature_tenths));
  assign mag_in       = raw[TEMP_W-1] ? (~raw + TEMP_W'(1)) : raw;
  assign conv_done    = (conv_cnt == CONV_STEPS);

  always_comb begin
    for (int k = 0; k < BCD_DIGITS; k++) begin
      bcd_adj[k] = (bcd[k] >= 4'd5) ? (bcd[k] + 4'd3) : bcd[k];
    end
  end
  assign bcd_adj_flat = bcd_adj;

  always_comb begin
    top_pos = DIG_W'(1);
    for (int k = 2; k < BCD_DIGITS; k++) begin
      if (bcd[k] != 4'd0) top_pos = DIG_W'(k);
    end
  end

  assign dig_sel = top_pos - idx[DIG_W-1:0];

  always_comb begin
    case (cmd.sel)
      SEL_EQ:    idx_end = (idx == (power_on ? ON_LAST : OFF_LAST));
      SEL_TEMP:  idx_end = (idx == TEMP_LAST);
      SEL_DIGIT: idx_end = (dig_sel == DIG_W'(1));
      default:   idx_end = 1'b1;
    endcase
  end

  always_comb begin
    case (cmd.sel)
      SEL_EQ:    char_next = eq_char(power_on, idx);
      SEL_TEMP:  char_next = temp_char(idx);
      SEL_SIGN:  char_next = CH_MINUS;
      SEL_DIGIT: char_next = CH_ZERO + CHAR_W'(bcd[dig_sel]);
      SEL_DOT:   char_next = CH_DOT;
      SEL_FRAC:  char_next = CH_ZERO + CHAR_W'(bcd[0]);
      default:   char_next = CH_NL;
    endcase
  end

  assign sts.press_acc = press_acc;
  assign sts.has_temp  = has_temp;
  assign sts.neg       = neg;
  assign sts.conv_done = conv_done;
  assign sts.out_free  = !out_valid || telemetry.ready;
  assign sts.idx_end   = idx_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_interval <= DEBOUNCE_RESET;
      invalid_code      <= signed'(INVALID_RESET);
      power_on          <= 1'b0;
      button_previous   <= 1'b0;
      last_edge_time    <= '0;
      edge_seen         <= 1'b0;
      has_temp          <= 1'b0;
      neg               <= 1'b0;
      conv_cnt          <= CONV_STEPS;
      idx               <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_DEBOUNCE: debounce_interval <= cfg.data;
          CFG_INVALID:  invalid_code      <= signed'(cfg.data);
          default: ;
        endcase
      end
      if (accept) begin
        button_previous <= sample.button_level;
      end
      if (press_acc) begin
        last_edge_time <= sample.time_ms;
        edge_seen      <= 1'b1;
        power_on       <= !power_on;
        has_temp       <= (sample.temperature_tenths != invalid_code);
        neg            <= raw[TEMP_W-1];
        conv_cnt       <= '0;
        idx            <= '0;
      end else begin
        if (!conv_done) conv_cnt <= conv_cnt + CNT_W'(1);
        if (cmd.emit) idx <= idx_end ? '0 : (idx + IDX_W'(1));
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (telemetry.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (press_acc) begin
      mag <= mag_in;
      bcd <= '0;
    end else if (!conv_done) begin
      bcd <= {bcd_adj_flat[4*BCD_DIGITS-2:0], mag[TEMP_W-1]};
      mag <= {mag[TEMP_W-2:0], 1'b0};
    end
    if (cmd.emit) begin
      out_char <= char_next;
      out_last <= cmd.last;
      out_eq   <= power_on;
    end
  end

  assign telemetry.valid           = out_valid;
  assign telemetry.char_code       = out_char;
  assign telemetry.last_byte       = out_last;
  assign telemetry.equipment_state = out_eq;

  `DTF_ASSERT_NEXT(a_press_toggles, press_acc, power_on != $past(power_on), "press did not toggle state")
  `DTF_ASSERT_NOW(a_digit_range, cmd.emit && (cmd.sel == SEL_DIGIT), (dig_sel >= DIG_W'(1)) && (dig_sel <= DIG_W'(9)), "digit select out of range")
  `DTF_ASSERT_NEXT(a_conv_holds, conv_done && !press_acc, conv_done, "conversion restarted without a press")

endmodule

// ===== rtl/dtf_controller.sv =====
// Controller state machine that sequences the text segments of one press.
`include "debounced_toggle_telemetry_formatter_macros.svh"

module dtf_controller (
  input  logic              clk,
  input  logic              rst,
  input  dtf_pkg::dtf_sts_t sts,
  output dtf_pkg::dtf_cmd_t cmd
);
  import dtf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EQ,
    S_TEMP,
    S_SIGN,
    S_DIGIT,
    S_DOT,
    S_FRAC,
    S_NL
  } state_t;

  state_t state;
  state_t state_next;
  logic   can_emit;

  always_comb begin
    cmd.idle = (state == S_IDLE);
    cmd.sel  = SEL_NL;
    can_emit = 1'b1;
    unique case (state)
      S_IDLE:  can_emit = 1'b0;
      S_EQ:    cmd.sel = SEL_EQ;
      S_TEMP:  cmd.sel = SEL_TEMP;
      S_SIGN:  cmd.sel = SEL_SIGN;
      S_DIGIT: begin
        cmd.sel  = SEL_DIGIT;
        can_emit = sts.conv_done;
      end
      S_DOT:   cmd.sel = SEL_DOT;
      S_FRAC:  begin
        cmd.sel  = SEL_FRAC;
        can_emit = sts.conv_done;
      end
      S_NL:    cmd.sel = SEL_NL;
      default: can_emit = 1'b0;
    endcase
    cmd.emit = can_emit && sts.out_free;
    cmd.last = ((state == S_EQ) && sts.idx_end && !sts.has_temp) || (state == S_NL);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (sts.press_acc) state_next = S_EQ;
      S_EQ:    if (cmd.emit && sts.idx_end) state_next = sts.has_temp ? S_TEMP : S_IDLE;
      S_TEMP:  if (cmd.emit && sts.idx_end) state_next = sts.neg ? S_SIGN : S_DIGIT;
      S_SIGN:  if (cmd.emit) state_next = S_DIGIT;
      S_DIGIT: if (cmd.emit && sts.idx_end) state_next = S_DOT;
      S_DOT:   if (cmd.emit) state_next = S_FRAC;
      S_FRAC:  if (cmd.emit) state_next = S_NL;
      S_NL:    if (cmd.emit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `DTF_ASSERT_NEXT(a_press_starts, sts.press_acc && (state == S_IDLE), state == S_EQ, "press did not start a run")
  `DTF_ASSERT_NEXT(a_last_ends, cmd.emit && cmd.last, state == S_IDLE, "run continued after its last byte")
  `DTF_ASSERT_NOW(a_digits_ready, cmd.emit && ((state == S_DIGIT) || (state == S_FRAC)), sts.conv_done, "digit sent before conversion finished")

endmodule

// ===== rtl/debounced_toggle_telemetry_formatter.sv =====
// A press moves the controller out of idle before its first byte is registered.
// Throughput: one byte per cycle while the sink is ready; the 32-step binary to BCD
// conversion started at acceptance can hold the first temperature digit until it ends.
// A press occupies the block, holding off new samples, until its last byte is emitted;
// any other sample is accepted without leaving idle.
// Reset (synchronous, active high) restores both registers and clears the press state.
module debounced_toggle_telemetry_formatter (
  input  logic        clk,
  input  logic        rst,
  dtf_cfg_if.sink     cfg,
  dtf_in_if.sink      sample,
  dtf_out_if.source   telemetry
);
  import dtf_pkg::*;

  dtf_cmd_t cmd;
  dtf_sts_t sts;

  dtf_controller u_ctl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  dtf_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg       (cfg),
    .sample    (sample),
    .telemetry (telemetry)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the debounced toggle telemetry formatter, with its own predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dtf_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int SETTLE_CYCLES = 64;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int PHASE_ITEMS   = 98;
  localparam int HOLD_CYCLES   = 400;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam logic [TIME_W-1:0] DEBOUNCE_AT_RESET = 32'd50;
  localparam logic [TEMP_W-1:0] NO_READING_AT_RESET = 32'h8000_0000;

  localparam string ON_LINE  = "equipment/0/state,on\n";
  localparam string OFF_LINE = "equipment/0/state,off\n";

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              eq;
  } tele_byte_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [TEMP_W-1:0]    data;
    logic                 btn;
    logic [TIME_W-1:0]    t;
    logic [TEMP_W-1:0]    temp;
    bit                   typed;
    string                text;
    logic                 eq;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  dtf_cfg_if cfg_ch ();
  dtf_in_if  sample_ch ();
  dtf_out_if tele_ch ();

  debounced_toggle_telemetry_formatter u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_ch),
    .sample    (sample_ch),
    .telemetry (tele_ch)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Predictor state and its copy of the registers.
  logic              eq_on;
  logic              btn_prev;
  logic              press_seen;
  logic [TIME_W-1:0] last_press_ms;
  logic [TIME_W-1:0] debounce_ms;
  logic [TEMP_W-1:0] no_reading_code;

  tele_byte_t  expected_bytes[$];
  stim_row_t   stim_rows[$];
  int unsigned mismatches   = 0;
  int unsigned cycles       = 0;
  int unsigned gap_pct      = 0;
  int unsigned stall_pct    = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left    = 0;

  function automatic void spell_bytes(input string text, input logic eq, ref tele_byte_t run[$]);
    tele_byte_t b;
    for (int k = 0; k < text.len(); k++) begin
      b.ch   = text[k];
      b.last = (k == text.len() - 1);
      b.eq   = eq;
      run.push_back(b);
    end
  endfunction

  function automatic void predict_press(input logic btn, input logic [TIME_W-1:0] t,
                                        input logic [TEMP_W-1:0] temp, ref tele_byte_t run[$]);
    string             line;
    logic [TEMP_W-1:0] mag;
    run = {};
    if (btn && !btn_prev && (!press_seen || (t - last_press_ms) >= debounce_ms)) begin
      last_press_ms = t;
      press_seen    = 1'b1;
      eq_on         = !eq_on;
      line          = eq_on ? ON_LINE : OFF_LINE;
      if (temp != no_reading_code) begin
        mag  = temp[TEMP_W-1] ? -temp : temp;
        line = {line, "temp,"};
        if (temp[TEMP_W-1]) line = {line, "-"};
        line = {line, $sformatf("%0d.%0d\n", mag / 10, mag % 10)};
      end
      spell_bytes(line, eq_on, run);
    end
    btn_prev = btn;
  endfunction

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
  endfunction

  task automatic put_sample(input logic btn, input logic [TIME_W-1:0] t,
                            input logic [TEMP_W-1:0] temp, input bit typed,
                            input string text, input logic eq);
    stim_row_t row;
    row.kind  = ROW_SAMPLE;
    row.idx   = CFG_DEBOUNCE;
    row.data  = '0;
    row.btn   = btn;
    row.t     = t;
    row.temp  = temp;
    row.typed = typed;
    row.text  = text;
    row.eq    = eq;
    stim_rows.push_back(row);
  endtask

  task automatic put_write(input logic [CFG_IDX_W-1:0] idx, input logic [TEMP_W-1:0] data);
    stim_row_t row;
    row.kind  = ROW_WRITE;
    row.idx   = idx;
    row.data  = data;
    row.btn   = 1'b0;
    row.t     = '0;
    row.temp  = '0;
    row.typed = 1'b0;
    row.text  = "";
    row.eq    = 1'b0;
    stim_rows.push_back(row);
  endtask

  task automatic send_sample(input logic btn, input logic [TIME_W-1:0] t,
                             input logic [TEMP_W-1:0] temp, input bit typed,
                             input string text, input logic eq);
    tele_byte_t run[$];
    while ($urandom_range(99) < gap_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid              <= 1'b1;
    sample_ch.button_level       <= btn;
    sample_ch.time_ms            <= t;
    sample_ch.temperature_tenths <= temp;
    do @(posedge clk); while (!sample_ch.ready);
    predict_press(btn, t, temp, run);
    if (typed) begin
      run = {};
      spell_bytes(text, eq, run);
    end
    foreach (run[k]) expected_bytes.push_back(run[k]);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TEMP_W-1:0] data,
                           input bit keep);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (!keep) cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_DEBOUNCE: debounce_ms = data;
      CFG_INVALID:  no_reading_code = data;
      default: ;
    endcase
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Every accepted request on the telemetry side is checked against the oldest expectation.
  always @(posedge clk) begin
    tele_byte_t want;
    if (rst) begin
      tele_ch.ready <= 1'b0;
    end else begin
      if (tele_ch.valid && tele_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          note_mismatch($sformatf("unexpected byte %02h last %0b state %0b",
                                  tele_ch.char_code, tele_ch.last_byte,
                                  tele_ch.equipment_state));
        end else begin
          want = expected_bytes.pop_front();
          if (tele_ch.char_code !== want.ch || tele_ch.last_byte !== want.last ||
              tele_ch.equipment_state !== want.eq) begin
            note_mismatch($sformatf("expected %02h last %0b state %0b, got %02h last %0b state %0b",
                                    want.ch, want.last, want.eq, tele_ch.char_code,
                                    tele_ch.last_byte, tele_ch.equipment_state));
          end
        end
      end
      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        tele_ch.ready <= 1'b0;
      end else if (hold_request != 0) begin
        hold_left     <= hold_request;
        hold_request  = 0;
        tele_ch.ready <= 1'b0;
      end else begin
        tele_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic              level;
    logic [TIME_W-1:0] clock_ms;
    logic [TEMP_W-1:0] reading;
    logic [TIME_W-1:0] deb;
    logic [TEMP_W-1:0] inv;
    int unsigned       pick;
    int unsigned       span;

    rst                          <= 1'b1;
    sample_ch.valid              <= 1'b0;
    sample_ch.button_level       <= 1'b0;
    sample_ch.time_ms            <= '0;
    sample_ch.temperature_tenths <= '0;
    cfg_ch.valid                 <= 1'b0;
    cfg_ch.index                 <= CFG_DEBOUNCE;
    cfg_ch.data                  <= '0;

    eq_on           = 1'b0;
    btn_prev        = 1'b0;
    press_seen      = 1'b0;
    last_press_ms   = '0;
    debounce_ms     = DEBOUNCE_AT_RESET;
    no_reading_code = NO_READING_AT_RESET;

    put_sample(1'b0, 32'd0, 32'd0, 1'b1, "", 1'b0);
    put_sample(1'b1, 32'd5, 32'hFFFF_FFFC, 1'b1, {ON_LINE, "temp,-0.4\n"}, 1'b1);
    put_sample(1'b1, 32'd6, 32'd7, 1'b0, "", 1'b0);
    put_sample(1'b0, 32'd7, 32'd7, 1'b1, "", 1'b0);
    put_sample(1'b1, 32'd20, 32'd123, 1'b1, "", 1'b0);
    put_sample(1'b0, 32'd30, 32'd0, 1'b1, "", 1'b0);
    put_sample(1'b1, 32'd55, 32'h8000_0000, 1'b1, OFF_LINE, 1'b0);
    put_sample(1'b0, 32'd56, 32'd0, 1'b1, "", 1'b0);
    put_sample(1'b1, 32'd104, 32'h7FFF_FFFF, 1'b1, "", 1'b0);
    put_sample(1'b0, 32'd104, 32'd0, 1'b0, "", 1'b0);
    put_sample(1'b1, 32'd105, 32'h7FFF_FFFF, 1'b1, {ON_LINE, "temp,214748364.7\n"}, 1'b1);
    put_sample(1'b0, 32'hFFFF_FFF0, 32'd0, 1'b1, "", 1'b0);
    put_sample(1'b1, 32'hFFFF_FFF0, 32'd0, 1'b1, {OFF_LINE, "temp,0.0\n"}, 1'b0);
    put_sample(1'b0, 32'h0000_0010, 32'd9, 1'b1, "", 1'b0);
    put_sample(1'b1, 32'h0000_0021, 32'd9, 1'b1, "", 1'b0);
    put_sample(1'b0, 32'h0000_0021, 32'd9, 1'b0, "", 1'b0);
    put_sample(1'b1, 32'h0000_0022, 32'hFFFF_FFFF, 1'b1, {ON_LINE, "temp,-0.1\n"}, 1'b1);
    put_write(CFG_DEBOUNCE, 32'd0);
    put_write(CFG_INVALID, 32'd0);
    put_sample(1'b0, 32'h0000_0022, 32'd0, 1'b1, "", 1'b0);
    put_sample(1'b1, 32'h0000_0022, 32'h8000_0000, 1'b1,
               {OFF_LINE, "temp,-214748364.8\n"}, 1'b0);
    put_sample(1'b0, 32'h0000_0022, 32'd0, 1'b0, "", 1'b0);
    put_sample(1'b1, 32'h0000_0022, 32'd0, 1'b1, ON_LINE, 1'b1);
    put_write(CFG_DEBOUNCE, 32'hFFFF_FFFF);
    put_write(CFG_INVALID, 32'h7FFF_FFFF);
    put_write(CFG_SPARE_A, 32'd0);
    put_write(CFG_SPARE_B, 32'd0);
    put_sample(1'b0, 32'd0, 32'd0, 1'b1, "", 1'b0);
    put_sample(1'b1, 32'h0000_0021, 32'h7FFF_FFFF, 1'b1, OFF_LINE, 1'b0);
    put_sample(1'b0, 32'd0, 32'd0, 1'b0, "", 1'b0);
    put_sample(1'b1, 32'h0000_0020, 32'h8000_0000, 1'b1,
               {ON_LINE, "temp,-214748364.8\n"}, 1'b1);
    put_sample(1'b0, 32'd0, 32'd0, 1'b1, "", 1'b0);
    put_sample(1'b1, 32'h0000_0050, 32'd99, 1'b1, "", 1'b0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < stim_rows.size(); i++) begin
      if (stim_rows[i].kind == ROW_WRITE) begin
        if (stim_rows[i-1].kind != ROW_WRITE) drain();
        write_reg(stim_rows[i].idx, stim_rows[i].data,
                  i + 1 < stim_rows.size() && stim_rows[i+1].kind == ROW_WRITE);
      end else begin
        send_sample(stim_rows[i].btn, stim_rows[i].t, stim_rows[i].temp,
                    stim_rows[i].typed, stim_rows[i].text, stim_rows[i].eq);
      end
    end

    level    = 1'b1;
    clock_ms = 32'h0000_0050;
    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        0: begin
          gap_pct = 0;  stall_pct = 0;  deb = 32'd50;  inv = 32'h8000_0000;
        end
        1: begin
          gap_pct = 70; stall_pct = 0;  deb = 32'd0;   inv = $urandom;
        end
        2: begin
          gap_pct = 0;  stall_pct = 70; deb = $urandom_range(1, 300); inv = 32'd0;
        end
        default: begin
          gap_pct = 12; stall_pct = 12; deb = 32'd1000; inv = 32'h7FFF_FFFF;
        end
      endcase
      write_reg(CFG_DEBOUNCE, deb, 1'b1);
      write_reg(CFG_INVALID, inv, 1'b0);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == 30) hold_request = HOLD_CYCLES;
        if (p == 1 && n == 60) drain();

        pick  = $urandom_range(99);
        level = (pick < 80) ? !level : 1'($urandom_range(1));

        pick = $urandom_range(99);
        span = (debounce_ms > 32'd2000) ? 2000 : debounce_ms;
        if (pick < 70) clock_ms += $urandom_range(2 * span + 4);
        else if (pick < 80) clock_ms += debounce_ms - $urandom_range(1);
        else if (pick < 90) clock_ms = $urandom;
        else clock_ms += $urandom_range(3);

        pick = $urandom_range(99);
        if (pick < 40) reading = $urandom_range(4000) - 2000;
        else if (pick < 55) reading = $urandom_range(18) - 9;
        else if (pick < 75) reading = $urandom;
        else if (pick < 85) reading = no_reading_code;
        else begin
          case ($urandom_range(3))
            0: reading = 32'h8000_0000;
            1: reading = 32'h7FFF_FFFF;
            2: reading = 32'hFFFF_FFFF;
            default: reading = 32'd0;
          endcase
        end

        send_sample(level, clock_ms, reading, 1'b0, "", 1'b0);
      end
    end

    drain();
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
